// ----- rtl/reps_pkg.sv -----
`default_nettype none

package reps_pkg;

    // Configuration register indexes.
    localparam logic [2:0] REG_EYE_WIDTH       = 3'd0;
    localparam logic [2:0] REG_EYE_HEIGHT      = 3'd1;
    localparam logic [2:0] REG_CORNER_RADIUS   = 3'd2;
    localparam logic [2:0] REG_UPPER_LID_DEPTH = 3'd3;
    localparam logic [2:0] REG_UPPER_LID_SLANT = 3'd4;
    localparam logic [2:0] REG_LOWER_LID_RISE  = 3'd5;
    localparam logic [2:0] REG_LOWER_LID_SLANT = 3'd6;
    localparam logic [2:0] REG_PUPIL_MODE      = 3'd7;

    // Pupil styles.
    localparam logic [1:0] PUPIL_SOLID      = 2'd0;
    localparam logic [1:0] PUPIL_HIGHLIGHTS = 2'd1;
    localparam logic [1:0] PUPIL_SHOCK      = 2'd2;
    localparam logic [1:0] PUPIL_DIZZY      = 2'd3;

    // Register values after reset.
    localparam logic [6:0] EYE_WIDTH_RST     = 7'd68;
    localparam logic [5:0] EYE_HEIGHT_RST    = 6'd46;
    localparam logic [5:0] CORNER_RADIUS_RST = 6'd14;

    typedef struct packed {
        logic [6:0]        eye_width;
        logic [5:0]        eye_height;
        logic [5:0]        corner_radius;
        logic [5:0]        upper_lid_depth;
        logic signed [6:0] upper_lid_slant;
        logic [5:0]        lower_lid_rise;
        logic signed [6:0] lower_lid_slant;
        logic [1:0]        pupil_mode;
    } cfg_t;

    typedef struct packed {
        logic [6:0]  pixel_x;
        logic [5:0]  pixel_y;
        logic [6:0]  eye_center_x;
        logic [5:0]  eye_center_y;
        logic        right_side;
        logic [31:0] frame_count;
    } pix_t;

    // Partial results handed from the geometry stage to the decision stage.
    typedef struct packed {
        logic                kill;        // zero size or off screen
        logic                closed;      // lid nearly shut, draw the line
        logic                closed_lit;
        logic                in_box;
        logic                in_corner;
        logic [12:0]         corner_sum;
        logic [11:0]         corner_rsq;
        logic signed [15:0]  prod_upper;  // side * upper slant * dx
        logic signed [15:0]  prod_lower;
        logic signed [9:0]   room_upper;  // y - y0 - depth
        logic signed [9:0]   room_lower;  // y1 - rise - y
        logic [14:0]         d2;
        logic [15:0]         glint_big;
        logic [15:0]         glint_small;
        logic                frame_phase; // parity of frame_count / 3
    } geom_t;

endpackage

`default_nettype wire

// ----- rtl/reps_geom.sv -----
`default_nettype none

// Geometry stage: distances, squares and slant products for one pixel.
module reps_geom
    import reps_pkg::*;
(
    input  wire pix_t  pix,
    input  wire cfg_t  cfg,
    input  wire        off_screen,
    output geom_t      geom
);

    // Residue of a value up to fifteen modulo three.
    function automatic logic [1:0] mod3_small(input logic [3:0] v);
        logic [1:0] m;
        unique case (v)
            4'd0, 4'd3, 4'd6, 4'd9, 4'd12, 4'd15: m = 2'd0;
            4'd1, 4'd4, 4'd7, 4'd10, 4'd13:       m = 2'd1;
            default:                              m = 2'd2;
        endcase
        return m;
    endfunction

    logic signed [7:0] dx;
    logic signed [6:0] dy;
    logic [6:0]        adx;
    logic [5:0]        ady;
    logic [5:0]        r_w;
    logic [5:0]        r_c;
    logic signed [7:0] len_line;
    logic [6:0]        half_abs;
    logic              line_row;
    logic signed [9:0] px10, py10, x0, x1, y0, y1, cl, cr, ct, cb;
    logic signed [9:0] cdx, cdy;
    logic              in_corner;
    logic [11:0]       sq_cdx, sq_cdy;
    logic signed [7:0] su, sl;
    logic [13:0]       sq_dx;
    logic [11:0]       sq_dy;
    logic signed [8:0] ex, hx;
    logic signed [7:0] ey;
    logic [7:0]        aex, ahx;
    logic [6:0]        aey;
    logic [2:0]        lvl1 [8];
    logic [3:0]        lvl2 [4];
    logic [4:0]        lvl3 [2];
    logic [5:0]        digit_sum;
    logic [3:0]        fold;
    logic [1:0]        m3;

    always_comb begin
        dx  = $signed({1'b0, pix.pixel_x}) - $signed({1'b0, pix.eye_center_x});
        dy  = $signed({1'b0, pix.pixel_y}) - $signed({1'b0, pix.eye_center_y});
        adx = dx[7] ? 7'(-dx) : dx[6:0];
        ady = dy[6] ? 6'(-dy) : dy[5:0];

        // Corner radius limited to half the width, then half the height.
        r_w = ({cfg.corner_radius, 1'b0} > cfg.eye_width) ? cfg.eye_width[6:1]
                                                          : cfg.corner_radius;
        r_c = ({r_w, 1'b0} > {1'b0, cfg.eye_height}) ? {1'b0, cfg.eye_height[5:1]} : r_w;

        // Closed eye: a two-row line of half length |(w - 12) / 2|.
        len_line = $signed({1'b0, cfg.eye_width}) - 8'sd12;
        half_abs = len_line[7] ? 7'((-len_line) >>> 1) : 7'(len_line >>> 1);
        line_row = (pix.pixel_y == pix.eye_center_y) ||
                   ({1'b0, pix.pixel_y} == ({1'b0, pix.eye_center_y} + 7'd1));

        // Bounding box.
        px10 = $signed({3'b0, pix.pixel_x});
        py10 = $signed({4'b0, pix.pixel_y});
        x0   = $signed({3'b0, pix.eye_center_x}) - $signed({4'b0, cfg.eye_width[6:1]});
        x1   = x0 + $signed({3'b0, cfg.eye_width}) - 10'sd1;
        y0   = $signed({4'b0, pix.eye_center_y}) - $signed({5'b0, cfg.eye_height[5:1]});
        y1   = y0 + $signed({4'b0, cfg.eye_height}) - 10'sd1;
        cl   = x0 + $signed({4'b0, r_c});
        cr   = x1 - $signed({4'b0, r_c});
        ct   = y0 + $signed({4'b0, r_c});
        cb   = y1 - $signed({4'b0, r_c});

        // Corner regions, in the order top left, top right, bottom left, bottom right.
        in_corner = 1'b1;
        cdx       = cl - px10;
        cdy       = ct - py10;
        priority if (px10 < cl && py10 < ct) begin
            cdx = cl - px10;
            cdy = ct - py10;
        end else if (px10 > cr && py10 < ct) begin
            cdx = px10 - cr;
            cdy = ct - py10;
        end else if (px10 < cl && py10 > cb) begin
            cdx = cl - px10;
            cdy = py10 - cb;
        end else if (px10 > cr && py10 > cb) begin
            cdx = px10 - cr;
            cdy = py10 - cb;
        end else begin
            in_corner = 1'b0;
        end
        sq_cdx = cdx[5:0] * cdx[5:0];
        sq_cdy = cdy[5:0] * cdy[5:0];

        // Lid slants mirrored by screen side.
        su = pix.right_side ? -$signed({cfg.upper_lid_slant[6], cfg.upper_lid_slant})
                            :  $signed({cfg.upper_lid_slant[6], cfg.upper_lid_slant});
        sl = pix.right_side ? -$signed({cfg.lower_lid_slant[6], cfg.lower_lid_slant})
                            :  $signed({cfg.lower_lid_slant[6], cfg.lower_lid_slant});

        // Pupil distances; highlight centers are offset toward the inner side.
        sq_dx = adx * adx;
        sq_dy = ady * ady;
        ex    = pix.right_side ? ($signed({dx[7], dx}) + 9'sd8) : ($signed({dx[7], dx}) - 9'sd8);
        ey    = $signed({dy[6], dy}) + 8'sd8;
        hx    = pix.right_side ? ($signed({dx[7], dx}) + 9'sd1) : ($signed({dx[7], dx}) - 9'sd1);
        aex   = ex[8] ? 8'(-ex) : ex[7:0];
        aey   = ey[7] ? 7'(-ey) : ey[6:0];
        ahx   = hx[8] ? 8'(-hx) : hx[7:0];

        // frame_count / 3 is odd exactly when frame_count mod 6 is 3, 4 or 5.
        for (int i = 0; i < 8; i++) begin
            lvl1[i] = 3'(pix.frame_count[4*i +: 2]) + 3'(pix.frame_count[4*i+2 +: 2]);
        end
        for (int i = 0; i < 4; i++) begin
            lvl2[i] = 4'(lvl1[2*i]) + 4'(lvl1[2*i+1]);
        end
        for (int i = 0; i < 2; i++) begin
            lvl3[i] = 5'(lvl2[2*i]) + 5'(lvl2[2*i+1]);
        end
        digit_sum = 6'(lvl3[0]) + 6'(lvl3[1]);
        fold      = 4'(digit_sum[5:4]) + 4'(digit_sum[3:2]) + 4'(digit_sum[1:0]);
        m3        = mod3_small(fold);

        geom.kill        = off_screen || (cfg.eye_width == 7'd0) || (cfg.eye_height == 6'd0);
        geom.closed      = ({1'b0, cfg.upper_lid_depth} + 7'd2) >= {1'b0, cfg.eye_height};
        geom.closed_lit  = line_row && (adx <= half_abs);
        geom.in_box      = (px10 >= x0) && (px10 <= x1) && (py10 >= y0) && (py10 <= y1);
        geom.in_corner   = in_corner;
        geom.corner_sum  = 13'(sq_cdx) + 13'(sq_cdy);
        geom.corner_rsq  = r_c * r_c;
        geom.prod_upper  = su * dx;
        geom.prod_lower  = sl * dx;
        geom.room_upper  = py10 - y0 - $signed({4'b0, cfg.upper_lid_depth});
        geom.room_lower  = y1 - $signed({4'b0, cfg.lower_lid_rise}) - py10;
        geom.d2          = 15'(sq_dx) + 15'(sq_dy);
        geom.glint_big   = (16'(aex) * 16'(aex)) + (16'(aey) * 16'(aey));
        geom.glint_small = (16'(ahx) * 16'(ahx)) + 16'(sq_dy);
        geom.frame_phase = (pix.frame_count[0] && m3 == 2'd0) ||
                           (!pix.frame_count[0] && m3 == 2'd1) ||
                           (pix.frame_count[0] && m3 == 2'd2);
    end

endmodule

`default_nettype wire

// ----- rtl/reps_decide.sv -----
`default_nettype none

// Decision stage: lid division, corner and pupil tests, final pixel value.
module reps_decide
    import reps_pkg::*;
(
    input  wire geom_t       geom,
    input  wire [1:0]        pupil_mode,
    output logic             lit
);

    logic signed [15:0] cut_upper;
    logic signed [15:0] cut_lower;
    logic [14:0]        ring_prod;
    logic               pupil_cut;

    always_comb begin
        // Divide by sixteen rounding toward zero: bias negative values first.
        cut_upper = (geom.prod_upper + $signed({12'b0, {4{geom.prod_upper[15]}}})) >>> 4;
        cut_lower = (geom.prod_lower + $signed({12'b0, {4{geom.prod_lower[15]}}})) >>> 4;

        // Ring index d2 / 20 as (d2 / 4) * 205 / 1024; exact while d2 stays below 512.
        ring_prod = geom.d2[8:2] * 8'd205;

        unique case (pupil_mode)
            PUPIL_HIGHLIGHTS: pupil_cut = (geom.glint_big <= 16'd16) ||
                                          (geom.glint_small <= 16'd3);
            PUPIL_SHOCK:      pupil_cut = (geom.d2 <= 15'd36) && (geom.d2 > 15'd4);
            PUPIL_DIZZY:      pupil_cut = (geom.d2 <= 15'd300) &&
                                          !(geom.frame_phase ^ ring_prod[10]);
            default:          pupil_cut = 1'b0;
        endcase

        priority if (geom.kill) begin
            lit = 1'b0;
        end else if (geom.closed) begin
            lit = geom.closed_lit;
        end else if (!geom.in_box) begin
            lit = 1'b0;
        end else if (geom.in_corner && (geom.corner_sum > {1'b0, geom.corner_rsq})) begin
            lit = 1'b0;
        end else if (geom.room_upper <= cut_upper) begin
            lit = 1'b0;
        end else if (cut_lower >= geom.room_lower) begin
            lit = 1'b0;
        end else begin
            lit = !pupil_cut;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/robot_eye_pixel_shader.sv -----
`default_nettype none

// Robot eye pixel shader.
//
// Each beat on the s_ channel carries one screen pixel together with the eye
// center, the screen side and the animation frame number. For every input beat
// the block returns exactly one beat on the m_ channel whose bit 0 says whether
// the pixel is drawn white. The eye shape (size, corner radius, lids, pupil
// style) comes from eight configuration registers written through the cfg_
// port; write them only while no pixel is in flight.
//
// The datapath has two register stages: the input register and the output
// register, with the geometry and decision logic between them. A result is
// worked out from the input register and captured in the output register,
// where it shows on m_tvalid; one pixel per clock is sustained while m_tready
// stays high. Each stage advances when the stage after it is empty or moving,
// so a stall on m_tready fills the input register first and only then drops
// s_tready; nothing is lost or repeated.
//
// A synchronous low aresetn empties the pipeline and loads the register
// defaults: 68 by 46 pixel eye, radius 14, open lids, solid pupil.
module robot_eye_pixel_shader
    import reps_pkg::*;
#(
    parameter int unsigned SCREEN_WIDTH  = 128,
    parameter int unsigned SCREEN_HEIGHT = 64
) (
    input  wire         aclk,
    input  wire         aresetn,

    input  wire         s_tvalid,
    output logic        s_tready,
    // [6:0] pixel_x, [12:7] pixel_y, [19:13] eye_center_x, [25:20] eye_center_y,
    // [57:26] frame_count, [63:58] zero
    input  wire  [63:0] s_tdata,
    // [0] right_side
    input  wire         s_tuser,

    output logic        m_tvalid,
    input  wire         m_tready,
    // [0] lit, [7:1] zero
    output logic [7:0]  m_tdata,

    input  wire         cfg_wr_en,
    input  wire  [2:0]  cfg_index,
    input  wire  [6:0]  cfg_wdata
);

    cfg_t  cfg_reg;
    pix_t  in_next;
    pix_t  in_reg;
    logic  in_valid_reg;
    geom_t geom_next;
    logic  lit_next;
    logic  lit_reg;
    logic  m_valid_reg;
    logic  off_screen;
    logic  out_en;
    logic  in_en;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.eye_width       <= EYE_WIDTH_RST;
            cfg_reg.eye_height      <= EYE_HEIGHT_RST;
            cfg_reg.corner_radius   <= CORNER_RADIUS_RST;
            cfg_reg.upper_lid_depth <= '0;
            cfg_reg.upper_lid_slant <= '0;
            cfg_reg.lower_lid_rise  <= '0;
            cfg_reg.lower_lid_slant <= '0;
            cfg_reg.pupil_mode      <= PUPIL_SOLID;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_EYE_WIDTH:       cfg_reg.eye_width       <= cfg_wdata;
                REG_EYE_HEIGHT:      cfg_reg.eye_height      <= cfg_wdata[5:0];
                REG_CORNER_RADIUS:   cfg_reg.corner_radius   <= cfg_wdata[5:0];
                REG_UPPER_LID_DEPTH: cfg_reg.upper_lid_depth <= cfg_wdata[5:0];
                REG_UPPER_LID_SLANT: cfg_reg.upper_lid_slant <= $signed(cfg_wdata);
                REG_LOWER_LID_RISE:  cfg_reg.lower_lid_rise  <= cfg_wdata[5:0];
                REG_LOWER_LID_SLANT: cfg_reg.lower_lid_slant <= $signed(cfg_wdata);
                REG_PUPIL_MODE:      cfg_reg.pupil_mode      <= cfg_wdata[1:0];
            endcase
        end
    end

    // Stage enables: a stage loads when the next one is empty or moving on.
    assign out_en   = !m_valid_reg || m_tready;
    assign in_en    = !in_valid_reg || out_en;
    assign s_tready = in_en;

    always_comb begin
        in_next.pixel_x      = s_tdata[6:0];
        in_next.pixel_y      = s_tdata[12:7];
        in_next.eye_center_x = s_tdata[19:13];
        in_next.eye_center_y = s_tdata[25:20];
        in_next.right_side   = s_tuser;
        in_next.frame_count  = s_tdata[57:26];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (in_en) begin
                in_valid_reg <= s_tvalid;
            end
            if (out_en) begin
                m_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (in_en && s_tvalid) begin
            in_reg <= in_next;
        end
        if (out_en && in_valid_reg) begin
            lit_reg <= lit_next;
        end
    end

    // Pixels outside the visible screen are never drawn.
    assign off_screen = (32'(in_reg.pixel_x) >= SCREEN_WIDTH) ||
                        (32'(in_reg.pixel_y) >= SCREEN_HEIGHT);

    reps_geom u_geom (
        .pix        (in_reg),
        .cfg        (cfg_reg),
        .off_screen (off_screen),
        .geom       (geom_next)
    );

    reps_decide u_decide (
        .geom       (geom_next),
        .pupil_mode (cfg_reg.pupil_mode),
        .lit        (lit_next)
    );

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'b0, lit_reg};

endmodule

`default_nettype wire

// ----- sim/eye_shade_checker.sv -----
`timescale 1ns / 1ps

// Watches both streams and the register port of the eye shader, keeps its own
// copy of the eye registers, works out the lit bit of every accepted pixel and
// compares it with the result beats in order.
module eye_shade_checker
    import reps_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 128,
    parameter int SCREEN_HEIGHT = 64
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    input  wire         s_tready,
    input  wire  [63:0] s_tdata,
    input  wire         s_tuser,
    input  wire         m_tvalid,
    input  wire         m_tready,
    input  wire  [7:0]  m_tdata,
    input  wire         cfg_wr_en,
    input  wire  [2:0]  cfg_index,
    input  wire  [6:0]  cfg_wdata,
    output int unsigned fail_count,
    output int unsigned pending
);

    cfg_t eye_regs;
    logic lit_expected_q[$];

    function automatic logic shade_pixel(pix_t p, cfg_t c);
        int w, h, r, side, x, y, cx, cy;
        int x0, x1, y0, y1, cut, d2, rsq, cl, cr, ct, cb;
        int half, lo, hi, gx, gy, hx, hy, dx, dy, upper_slant, lower_slant;
        logic in_corner;
        logic [31:0] phase;
        w = c.eye_width;
        h = c.eye_height;
        r = c.corner_radius;
        upper_slant = $signed(c.upper_lid_slant);
        lower_slant = $signed(c.lower_lid_slant);
        side = p.right_side ? -1 : 1;
        x = p.pixel_x;
        y = p.pixel_y;
        cx = p.eye_center_x;
        cy = p.eye_center_y;

        if (w <= 0 || h <= 0) return 1'b0;
        if (x >= SCREEN_WIDTH || y >= SCREEN_HEIGHT) return 1'b0;
        if (r * 2 > w) r = w / 2;
        if (r * 2 > h) r = h / 2;

        // Nearly shut lid: a two-row line centered on the eye.
        if (int'(c.upper_lid_depth) >= h - 2) begin
            half = (w - 12) / 2;
            lo = (cx - half < cx + half) ? cx - half : cx + half;
            hi = (cx - half < cx + half) ? cx + half : cx - half;
            if (y != cy && y != cy + 1) return 1'b0;
            return (x >= lo && x <= hi);
        end

        x0 = cx - w / 2;
        x1 = x0 + w - 1;
        y0 = cy - h / 2;
        y1 = y0 + h - 1;
        if (x < x0 || x > x1 || y < y0 || y > y1) return 1'b0;

        // Rounded corners: only the four corner squares are tested.
        rsq = r * r;
        cl = x0 + r;
        cr = x1 - r;
        ct = y0 + r;
        cb = y1 - r;
        in_corner = 1'b1;
        dx = 0;
        dy = 0;
        if (x < cl && y < ct) begin
            dx = cl - x;
            dy = ct - y;
        end else if (x > cr && y < ct) begin
            dx = x - cr;
            dy = ct - y;
        end else if (x < cl && y > cb) begin
            dx = cl - x;
            dy = y - cb;
        end else if (x > cr && y > cb) begin
            dx = x - cr;
            dy = y - cb;
        end else begin
            in_corner = 1'b0;
        end
        if (in_corner && dx * dx + dy * dy > rsq) return 1'b0;

        // Integer division truncates toward zero, as the lid terms require.
        cut = y0 + int'(c.upper_lid_depth) + (upper_slant * side * (x - cx)) / 16;
        if (y <= cut) return 1'b0;
        cut = y1 - int'(c.lower_lid_rise) - (lower_slant * side * (x - cx)) / 16;
        if (y >= cut) return 1'b0;

        d2 = (x - cx) * (x - cx) + (y - cy) * (y - cy);
        if (c.pupil_mode == PUPIL_HIGHLIGHTS) begin
            gx = cx + 8 * side;
            gy = cy - 8;
            hx = gx - 7 * side;
            hy = gy + 8;
            if ((x - gx) * (x - gx) + (y - gy) * (y - gy) <= 16) return 1'b0;
            if ((x - hx) * (x - hx) + (y - hy) * (y - hy) <= 3) return 1'b0;
        end else if (c.pupil_mode == PUPIL_SHOCK) begin
            if (d2 <= 36 && d2 > 4) return 1'b0;
        end else if (c.pupil_mode == PUPIL_DIZZY) begin
            phase = p.frame_count / 32'd3 + 32'(d2 / 20);
            if (!phase[0] && d2 <= 300) return 1'b0;
        end
        return 1'b1;
    endfunction

    always @(posedge aclk) begin
        pix_t pix;
        logic lit_want;
        if (!aresetn) begin
            lit_expected_q.delete();
            eye_regs = '0;
            eye_regs.eye_width = EYE_WIDTH_RST;
            eye_regs.eye_height = EYE_HEIGHT_RST;
            eye_regs.corner_radius = CORNER_RADIUS_RST;
            fail_count <= 0;
            pending <= 0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_EYE_WIDTH:       eye_regs.eye_width = cfg_wdata;
                    REG_EYE_HEIGHT:      eye_regs.eye_height = cfg_wdata[5:0];
                    REG_CORNER_RADIUS:   eye_regs.corner_radius = cfg_wdata[5:0];
                    REG_UPPER_LID_DEPTH: eye_regs.upper_lid_depth = cfg_wdata[5:0];
                    REG_UPPER_LID_SLANT: eye_regs.upper_lid_slant = cfg_wdata;
                    REG_LOWER_LID_RISE:  eye_regs.lower_lid_rise = cfg_wdata[5:0];
                    REG_LOWER_LID_SLANT: eye_regs.lower_lid_slant = cfg_wdata;
                    REG_PUPIL_MODE:      eye_regs.pupil_mode = cfg_wdata[1:0];
                    default: ;
                endcase
            end

            // Results first: the oldest expectation belongs to an earlier beat.
            if (m_tvalid && m_tready) begin
                if (lit_expected_q.size() == 0) begin
                    $error("result beat with no pixel outstanding, lit=%0d", m_tdata[0]);
                    fail_count <= fail_count + 1;
                end else begin
                    lit_want = lit_expected_q.pop_front();
                    if (m_tdata[0] !== lit_want) begin
                        $error("lit mismatch: expected %0d, actual %0d", lit_want, m_tdata[0]);
                        fail_count <= fail_count + 1;
                    end
                end
            end

            if (s_tvalid && s_tready) begin
                pix.pixel_x = s_tdata[6:0];
                pix.pixel_y = s_tdata[12:7];
                pix.eye_center_x = s_tdata[19:13];
                pix.eye_center_y = s_tdata[25:20];
                pix.frame_count = s_tdata[57:26];
                pix.right_side = s_tuser;
                lit_expected_q.push_back(shade_pixel(pix, eye_regs));
            end
            pending <= lit_expected_q.size();
        end
    end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps

// Top of the eye shader bench. It resets the block, walks through a set of
// hand-picked eye shapes and pixels, and then through many random eye shapes,
// each with a run of random pixels clustered around the eye. The checker
// beside the block does all prediction and comparison; this module only makes
// stimulus and reports the verdict.
module tb_top;
    import reps_pkg::*;

    localparam int PIXELS_PER_SHAPE = 50;
    localparam int RANDOM_SHAPES    = 35;
    localparam int LONG_STALL       = 64;

    // Register write order used whenever a whole eye shape is programmed.
    localparam logic [2:0] REG_ORDER [8] = '{
        REG_EYE_WIDTH, REG_EYE_HEIGHT, REG_CORNER_RADIUS, REG_UPPER_LID_DEPTH,
        REG_UPPER_LID_SLANT, REG_LOWER_LID_RISE, REG_LOWER_LID_SLANT, REG_PUPIL_MODE
    };

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;
    logic        cfg_wr_en = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [6:0]  cfg_wdata = '0;

    int unsigned fail_count;
    int unsigned pending;

    // Idle rates in percent, set by the stimulus per phase.
    int send_idle_pct = 13;
    int recv_idle_pct = 62;

    // The stimulus asks for a long receiver hold-off by bumping this counter;
    // the receiver process serves each request once.
    int unsigned hold_requests = 0;
    int unsigned holds_served = 0;
    int          stall_left = 0;

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    robot_eye_pixel_shader dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    eye_shade_checker checker_i (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Receiver: random back-pressure, or a long counted hold-off on request.
    // While the hold-off runs, the sender keeps offering beats, so the
    // pipeline fills and s_tready must drop.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (holds_served != hold_requests) begin
            holds_served <= holds_served + 1;
            stall_left <= LONG_STALL;
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    function automatic cfg_t eye_shape(int w, int h, int r, int depth, int upper_slant,
                                       int rise, int lower_slant, logic [1:0] mode);
        cfg_t c;
        c.eye_width = 7'(w);
        c.eye_height = 6'(h);
        c.corner_radius = 6'(r);
        c.upper_lid_depth = 6'(depth);
        c.upper_lid_slant = 7'(upper_slant);
        c.lower_lid_rise = 6'(rise);
        c.lower_lid_slant = 7'(lower_slant);
        c.pupil_mode = mode;
        return c;
    endfunction

    // Random eye shape: mostly plausible shapes, some fully random, some
    // pinned to the register extremes.
    function automatic cfg_t random_eye();
        cfg_t c;
        int kind;
        int h;
        kind = $urandom_range(9);
        if (kind == 0) begin
            c = eye_shape($urandom_range(127), $urandom_range(63), $urandom_range(63),
                          $urandom_range(63), $urandom_range(127), $urandom_range(63),
                          $urandom_range(127), 2'($urandom_range(3)));
        end else if (kind == 1) begin
            c = eye_shape($urandom_range(1) ? 127 : 0, $urandom_range(1) ? 63 : 0,
                          $urandom_range(1) ? 63 : 0, $urandom_range(1) ? 63 : 0,
                          $urandom_range(1) ? 63 : -64, $urandom_range(1) ? 63 : 0,
                          $urandom_range(1) ? 63 : -64, 2'($urandom_range(3)));
        end else begin
            h = $urandom_range(63, 8);
            c = eye_shape($urandom_range(127, 16), h, $urandom_range(h / 2 + 4),
                          $urandom_range(h / 3), $urandom_range(127), $urandom_range(h / 3),
                          $urandom_range(127), 2'($urandom_range(3)));
            // Now and then shut the lid right at the closing threshold.
            if ($urandom_range(5) == 0)
                c.upper_lid_depth = 6'(h - 3 + $urandom_range(3));
        end
        return c;
    endfunction

    // Offer one pixel beat and return in the time step of its handshake.
    // s_tvalid stays high afterwards so back-to-back beats need no gap.
    task automatic send_pixel(input int px, input int py, input int cx, input int cy,
                              input logic right, input logic [31:0] frame);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {6'd0, frame, 6'(cy), 7'(cx), 6'(py), 7'(px)};
        s_tuser <= right;
        do @(posedge aclk); while (!s_tready);
    endtask

    // Registers may only change with no pixel in flight: stop offering, wait
    // for every outstanding result, then write all eight registers.
    task automatic set_eye(input cfg_t c);
        logic [6:0] value;
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        foreach (REG_ORDER[i]) begin
            case (REG_ORDER[i])
                REG_EYE_WIDTH:       value = c.eye_width;
                REG_EYE_HEIGHT:      value = c.eye_height;
                REG_CORNER_RADIUS:   value = c.corner_radius;
                REG_UPPER_LID_DEPTH: value = c.upper_lid_depth;
                REG_UPPER_LID_SLANT: value = c.upper_lid_slant;
                REG_LOWER_LID_RISE:  value = c.lower_lid_rise;
                REG_LOWER_LID_SLANT: value = c.lower_lid_slant;
                default:             value = c.pupil_mode;
            endcase
            cfg_index <= REG_ORDER[i];
            cfg_wdata <= value;
            @(posedge aclk);
        end
        cfg_wr_en <= 1'b0;
    endtask

    // Random pixel: usually inside or just around the eye box, sometimes
    // anywhere on screen. Offsets that run off the edge simply wrap.
    task automatic send_random_pixel(input cfg_t c);
        int cx, cy, px, py, spread_x, spread_y;
        logic [31:0] frame;
        cx = $urandom_range(127);
        cy = $urandom_range(63);
        spread_x = int'(c.eye_width) + 7;
        spread_y = int'(c.eye_height) + 7;
        if ($urandom_range(4) == 0) begin
            px = $urandom_range(127);
            py = $urandom_range(63);
        end else begin
            px = cx + int'($urandom_range(spread_x)) - spread_x / 2;
            py = cy + int'($urandom_range(spread_y)) - spread_y / 2;
            // Closed lids only light two rows; aim at them often.
            if (int'(c.upper_lid_depth) >= int'(c.eye_height) - 2 && $urandom_range(1))
                py = cy + $urandom_range(2) - 1;
        end
        frame = ($urandom_range(3) == 0) ? 32'($urandom_range(30)) : $urandom();
        send_pixel(px, py, cx, cy, 1'($urandom_range(1)), frame);
    endtask

    initial begin
        cfg_t shape;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset shape: 68 by 46, radius 14, open lids, solid pupil.
        send_pixel(64, 32, 64, 32, 1'b0, 32'd0);
        send_pixel(0, 0, 0, 0, 1'b1, 32'hFFFF_FFFF);
        send_pixel(127, 63, 127, 63, 1'b0, 32'hFFFF_FFFF);
        send_pixel(31, 10, 64, 32, 1'b0, 32'd0);  // outside the rounded corner
        send_pixel(97, 54, 64, 32, 1'b1, 32'd0);

        // Zero width, then zero height: nothing lights.
        set_eye(eye_shape(0, 46, 14, 0, 0, 0, 0, PUPIL_SOLID));
        send_pixel(64, 32, 64, 32, 1'b0, 32'd0);
        set_eye(eye_shape(68, 0, 14, 0, 0, 0, 0, PUPIL_SOLID));
        send_pixel(64, 32, 64, 32, 1'b0, 32'd0);

        // Closed lid: a line from 50 to 78 on rows 32 and 33.
        set_eye(eye_shape(40, 20, 5, 18, 0, 0, 0, PUPIL_SOLID));
        send_pixel(50, 32, 64, 32, 1'b0, 32'd0);
        send_pixel(78, 33, 64, 32, 1'b1, 32'd0);
        send_pixel(64, 34, 64, 32, 1'b0, 32'd0);
        send_pixel(79, 32, 64, 32, 1'b0, 32'd0);
        // Width below 12 gives a negative span length; the ends swap.
        set_eye(eye_shape(4, 20, 5, 18, 0, 0, 0, PUPIL_SOLID));
        send_pixel(60, 32, 64, 32, 1'b0, 32'd0);

        // Steep lid slants at both extremes, mirrored by screen side.
        set_eye(eye_shape(60, 40, 10, 5, -64, 5, 63, PUPIL_SOLID));
        send_pixel(80, 20, 64, 32, 1'b0, 32'd0);
        send_pixel(80, 20, 64, 32, 1'b1, 32'd0);
        send_pixel(48, 44, 64, 32, 1'b0, 32'd0);

        // Highlights: the big glint, then the small glint on the right eye and on
        // the left eye.
        set_eye(eye_shape(68, 46, 14, 0, 0, 0, 0, PUPIL_HIGHLIGHTS));
        send_pixel(72, 24, 64, 32, 1'b0, 32'd0);
        send_pixel(63, 32, 64, 32, 1'b1, 32'd0);
        send_pixel(65, 32, 64, 32, 1'b0, 32'd0);

        // Shock pupil: inside the ring and at its untouched center.
        set_eye(eye_shape(68, 46, 14, 0, 0, 0, 0, PUPIL_SHOCK));
        send_pixel(69, 32, 64, 32, 1'b0, 32'd0);
        send_pixel(64, 32, 64, 32, 1'b0, 32'd0);

        // Dizzy rings: the phase moves every third frame.
        set_eye(eye_shape(68, 46, 14, 0, 0, 0, 0, PUPIL_DIZZY));
        send_pixel(64, 32, 64, 32, 1'b0, 32'd0);
        send_pixel(64, 32, 64, 32, 1'b0, 32'd3);
        send_pixel(80, 32, 64, 32, 1'b1, 32'd0);
        send_pixel(80, 32, 64, 32, 1'b1, 32'hFFFF_FFFF);

        // Random shapes in three idle phases: a slow receiver, then a slow
        // sender, then full rate with one long receiver hold-off.
        for (int n = 0; n < RANDOM_SHAPES; n++) begin
            if (n == RANDOM_SHAPES / 3) begin
                send_idle_pct = 62;
                recv_idle_pct = 13;
            end else if (n == 2 * RANDOM_SHAPES / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            shape = random_eye();
            set_eye(shape);
            if (n == 2 * RANDOM_SHAPES / 3)
                hold_requests <= hold_requests + 1;
            repeat (PIXELS_PER_SHAPE) send_random_pixel(shape);
        end

        // Drain, then keep watching the two-stage pipeline for any stray beat.
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        if (fail_count == 0 && pending == 0) begin
            $display("** robot_eye_pixel_shader: PASSED **");
        end else begin
            $display("** robot_eye_pixel_shader: FAILED **");
        end
        $finish;
    end

    initial begin
        #4ms;
        $display("** robot_eye_pixel_shader: FAILED **");
        $finish;
    end

endmodule
